// ===== sv/gte_pkg.sv =====
// Package for the grouped tuple enumerator.
// Holds the payload structs, controller/datapath interface structs, FSM states and constants.
// No dependencies.
package gte_pkg;

   localparam int NUM_POS        = 4;
   localparam int MAX_TUPLE      = 4;
   localparam int NUM_GROUPS     = 16;
   localparam int MAX_GROUP_SIZE = 256;
   localparam int LEN_LIM        = (MAX_TUPLE < NUM_POS) ? MAX_TUPLE : NUM_POS;

   localparam int IDX_W  = 8;
   localparam int GRP_W  = 4;
   localparam int SIZE_W = 9;
   localparam int WK_W   = 9;
   localparam int LEN_W  = 3;
   localparam int POS_W  = 2;
   localparam int CNT_W  = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENUMERATE_LAST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE     = 1'b1;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   localparam logic [CNT_W-1:0] BATCH_RESET = 16'd10;

   typedef struct packed {
      logic              mode;
      logic [LEN_W-1:0]  tuple_length;
      logic [GRP_W-1:0]  group_0;
      logic [GRP_W-1:0]  group_1;
      logic [GRP_W-1:0]  group_2;
      logic [GRP_W-1:0]  group_3;
      logic [SIZE_W-1:0] size_0;
      logic [SIZE_W-1:0] size_1;
      logic [SIZE_W-1:0] size_2;
      logic [SIZE_W-1:0] size_3;
      logic              last_set;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] index_0;
      logic [IDX_W-1:0] index_1;
      logic [IDX_W-1:0] index_2;
      logic [IDX_W-1:0] index_3;
      logic             valid_res;
      logic             batch_end;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic adv_copy;
      logic bump;
      logic step;
      logic commit_ok;
      logic commit_fail;
      logic count_inc;
      logic count_clear;
      logic out_load;
      logic out_ok;
      logic out_be;
   } cmd_type;

   typedef struct packed {
      logic e_zero;
      logic set_live;
      logic step_found;
      logic step_fail;
      logic full_mode;
      logic final_set;
      logic batch_hit;
      logic count_nz;
      logic out_free;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_LOAD,
      ST_ADV_CHECK,
      ST_SEARCH,
      ST_LOOK_BUMP,
      ST_LOOK_SEARCH,
      ST_RESULT
   } state_type;

endpackage

// ===== sv/gte_datapath.sv =====
// Datapath of the grouped tuple enumerator: set registers, search cursor, batch counter,
// configuration registers and the result register. Depends on gte_pkg.
module gte_datapath import gte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  cmd_type               cmd,
   output status_type            status
);

   logic              enumerate_last_ff;
   logic [CNT_W-1:0]  batch_size_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [GRP_W-1:0]  grp_ff  [NUM_POS];
   logic [SIZE_W-1:0] size_ff [NUM_POS];
   logic [IDX_W-1:0]  pos_ff  [NUM_POS];
   logic [WK_W-1:0]   wk_ff   [NUM_POS];
   logic [WK_W-1:0]   wk_in   [NUM_POS];
   logic [POS_W-1:0]  p_ff;
   logic [POS_W-1:0]  p_in;
   logic              live_ff;
   logic              final_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [GRP_W-1:0]  req_grp [NUM_POS];
   logic [SIZE_W-1:0] req_sz  [NUM_POS];
   logic [LEN_W-1:0]  ld_len;
   logic [LEN_W-1:0]  e_pos;
   logic [POS_W-1:0]  e_last;
   logic [LEN_W-1:0]  p_next;
   logic              cur_ok;
   logic              at_end;
   logic [WK_W-1:0]   lb_vec [NUM_POS];
   logic [CNT_W-1:0]  count_next;

   assign req_grp[0] = req_data.group_0;
   assign req_grp[1] = req_data.group_1;
   assign req_grp[2] = req_data.group_2;
   assign req_grp[3] = req_data.group_3;
   assign req_sz[0]  = req_data.size_0;
   assign req_sz[1]  = req_data.size_1;
   assign req_sz[2]  = req_data.size_2;
   assign req_sz[3]  = req_data.size_3;

   always_comb begin
      if (req_data.tuple_length < 3'd1) begin
         ld_len = 3'd1;
      end else if (req_data.tuple_length > LEN_W'(LEN_LIM)) begin
         ld_len = LEN_W'(LEN_LIM);
      end else begin
         ld_len = req_data.tuple_length;
      end
   end

   always_comb begin
      if (enumerate_last_ff) begin
         e_pos = len_ff;
      end else if (len_ff == 3'd0) begin
         e_pos = 3'd0;
      end else begin
         e_pos = len_ff - 3'd1;
      end
   end

   assign e_last = POS_W'(e_pos - 3'd1);

   // Lower bound of each position: one past the largest earlier index of the same group.
   always_comb begin
      for (int j = 0; j < NUM_POS; j++) begin
         lb_vec[j] = '0;
         for (int q = 0; q < NUM_POS; q++) begin
            if (q < j && grp_ff[q] == grp_ff[j] && (wk_ff[q] + 9'd1) > lb_vec[j]) begin
               lb_vec[j] = wk_ff[q] + 9'd1;
            end
         end
      end
   end

   assign cur_ok     = wk_ff[p_ff] < size_ff[p_ff];
   assign p_next     = {1'b0, p_ff} + 3'd1;
   assign at_end     = p_next >= e_pos;
   assign count_next = count_ff + 16'd1;

   always_comb begin
      wk_in = wk_ff;
      p_in  = p_ff;
      if (cmd.load) begin
         for (int i = 0; i < NUM_POS; i++) begin
            wk_in[i] = '0;
         end
         p_in = '0;
      end else if (cmd.adv_copy) begin
         for (int i = 0; i < NUM_POS; i++) begin
            wk_in[i] = {1'b0, pos_ff[i]};
         end
         if (!enumerate_last_ff && len_ff != 3'd0) begin
            wk_in[POS_W'(len_ff - 3'd1)] = '0;
         end
      end else if (cmd.bump) begin
         wk_in[e_last] = wk_ff[e_last] + 9'd1;
         p_in          = e_last;
      end else if (cmd.step) begin
         if (cur_ok && !at_end) begin
            p_in                   = p_next[POS_W-1:0];
            wk_in[p_next[POS_W-1:0]] = lb_vec[p_next[POS_W-1:0]];
         end else if (!cur_ok && p_ff != '0) begin
            p_in              = p_ff - 2'd1;
            wk_in[p_ff - 2'd1] = wk_ff[p_ff - 2'd1] + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      wk_ff <= wk_in;
      p_ff  <= p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enumerate_last_ff <= 1'b0;
         batch_size_ff     <= BATCH_RESET;
         len_ff            <= '0;
         live_ff           <= 1'b0;
         final_ff          <= 1'b0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < NUM_POS; i++) begin
            grp_ff[i]  <= '0;
            size_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENUMERATE_LAST: enumerate_last_ff <= csr_wdata[0];
               CSR_BATCH_SIZE:     batch_size_ff     <= csr_wdata;
               default:            batch_size_ff     <= batch_size_ff;
            endcase
         end
         if (cmd.load) begin
            len_ff   <= ld_len;
            final_ff <= req_data.last_set;
            for (int i = 0; i < NUM_POS; i++) begin
               grp_ff[i]  <= GRP_W'(32'(req_grp[i]) % NUM_GROUPS);
               size_ff[i] <= (req_sz[i] > SIZE_W'(MAX_GROUP_SIZE)) ?
                             SIZE_W'(MAX_GROUP_SIZE) : req_sz[i];
            end
         end
         if (cmd.commit_ok) begin
            live_ff <= 1'b1;
            for (int i = 0; i < NUM_POS; i++) begin
               pos_ff[i] <= (LEN_W'(i) < len_ff) ? wk_ff[i][IDX_W-1:0] : '0;
            end
         end else if (cmd.commit_fail) begin
            live_ff <= 1'b0;
            for (int i = 0; i < NUM_POS; i++) begin
               pos_ff[i] <= '0;
            end
         end
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.count_inc) begin
            count_ff <= count_next;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.index_0   <= cmd.out_ok ? pos_ff[0] : '0;
         rsp_ff.index_1   <= cmd.out_ok ? pos_ff[1] : '0;
         rsp_ff.index_2   <= cmd.out_ok ? pos_ff[2] : '0;
         rsp_ff.index_3   <= cmd.out_ok ? pos_ff[3] : '0;
         rsp_ff.valid_res <= cmd.out_ok;
         rsp_ff.batch_end <= cmd.out_be;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.e_zero     = (e_pos == 3'd0);
   assign status.set_live   = live_ff;
   assign status.step_found = cur_ok && at_end;
   assign status.step_fail  = !cur_ok && (p_ff == '0);
   assign status.full_mode  = enumerate_last_ff;
   assign status.final_set  = final_ff;
   assign status.batch_hit  = (count_next >= batch_size_ff);
   assign status.count_nz   = (count_ff != '0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ===== sv/gte_ctrl.sv =====
// Controller of the grouped tuple enumerator: sequences load, advance, search,
// batch look-ahead and result hand-off. Depends on gte_pkg.
module gte_ctrl import gte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      ok_ff;
   logic      ok_in;
   logic      be_ff;
   logic      be_in;
   logic      found_ev;
   logic      fail_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
         be_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         be_ff    <= be_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      be_in    = be_ff;
      cmd      = '0;
      found_ev = 1'b0;
      fail_ev  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_PREP_LOAD;
               end else begin
                  cmd.adv_copy = 1'b1;
                  state_in     = ST_ADV_CHECK;
               end
            end
         end
         ST_PREP_LOAD: begin
            if (status.e_zero) begin
               found_ev = 1'b1;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_ADV_CHECK: begin
            if (!status.set_live || status.e_zero) begin
               fail_ev = 1'b1;
            end else begin
               cmd.bump = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.step_found) begin
               found_ev = 1'b1;
            end else if (status.step_fail) begin
               fail_ev = 1'b1;
            end
         end
         ST_LOOK_BUMP: begin
            if (status.e_zero) begin
               cmd.count_clear = 1'b1;
               be_in           = 1'b1;
               state_in        = ST_RESULT;
            end else begin
               cmd.bump = 1'b1;
               state_in = ST_LOOK_SEARCH;
            end
         end
         ST_LOOK_SEARCH: begin
            cmd.step = 1'b1;
            if (status.step_found) begin
               cmd.count_inc = 1'b1;
               be_in         = 1'b0;
               state_in      = ST_RESULT;
            end else if (status.step_fail) begin
               cmd.count_clear = 1'b1;
               be_in           = 1'b1;
               state_in        = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_ok   = ok_ff;
               cmd.out_be   = be_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (found_ev) begin
         cmd.commit_ok = 1'b1;
         ok_in         = 1'b1;
         be_in         = 1'b0;
         state_in      = ST_RESULT;
         if (status.full_mode) begin
            if (status.batch_hit) begin
               cmd.count_clear = 1'b1;
               be_in           = 1'b1;
            end else if (status.final_set) begin
               state_in = ST_LOOK_BUMP;
            end else begin
               cmd.count_inc = 1'b1;
            end
         end
      end

      if (fail_ev) begin
         cmd.commit_fail = 1'b1;
         ok_in           = 1'b0;
         be_in           = 1'b0;
         state_in        = ST_RESULT;
         if (status.full_mode && status.final_set && status.count_nz) begin
            cmd.count_clear = 1'b1;
            be_in           = 1'b1;
         end
      end
   end

endmodule

// ===== sv/grouped_tuple_enumerator_top.sv =====
// Grouped tuple enumerator, top level. One transaction is worked at a time.
// A transaction passes from idle through the load or advance check and the search steps of
// the shared step unit to the result state; skipped empty subtrees add search steps, and the
// last-set look-ahead in full mode adds a bump and its own. A new transaction is accepted in
// the cycle after the result is loaded; a result still waiting in the output register stalls.
// Synchronous active-high reset clears the set, batch counter and configuration (batch size 10).
module grouped_tuple_enumerator_top import gte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gte_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== test/tb_grouped_tuple_enumerator_checker.sv =====
// Checker for the grouped tuple enumerator: watches the request, result and register ports,
// predicts every result in order and compares it field by field.
// Depends on gte_pkg.
`timescale 1ns / 1ps

module tb_grouped_tuple_enumerator_checker import gte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    outstanding,
   output int                    result_count,
   output int                    tuple_count,
   output int                    close_count
);

   logic             full_mode;
   logic [CNT_W-1:0] batch_limit;

   logic [IDX_W-1:0]  cur_index [NUM_POS];
   logic [GRP_W-1:0]  cur_group [NUM_POS];
   logic [SIZE_W-1:0] cur_size  [NUM_POS];
   logic [LEN_W-1:0]  cur_length;
   logic              set_open;
   logic              final_set;
   logic [CNT_W-1:0]  batch_fill;
   logic [WK_W-1:0]   probe     [NUM_POS];

   rsp_type tuples_due [$];

   function automatic logic [WK_W-1:0] floor_of(int p);
      int lb;
      lb = 0;
      for (int q = 0; q < p; q++) begin
         if (cur_group[q] == cur_group[p] && int'(probe[q]) + 1 > lb)
            lb = int'(probe[q]) + 1;
      end
      return WK_W'(lb);
   endfunction

   // Depth-first walk from position p, whose candidate is already in probe.
   function automatic logic descend(int e, int p);
      while (1) begin
         if (probe[p] < cur_size[p]) begin
            p++;
            if (p >= e)
               return 1'b1;
            probe[p] = floor_of(p);
         end else begin
            if (p == 0)
               return 1'b0;
            p--;
            probe[p] = probe[p] + 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic first_tuple(int e);
      if (e == 0)
         return 1'b1;
      probe[0] = floor_of(0);
      return descend(e, 0);
   endfunction

   function automatic logic next_tuple(int e);
      if (e == 0)
         return 1'b0;
      probe[e-1] = probe[e-1] + 1'b1;
      return descend(e, e - 1);
   endfunction

   function automatic int enum_span();
      int len;
      len = cur_length;
      if (len > NUM_POS)
         len = NUM_POS;
      if (full_mode)
         return len;
      return (len == 0) ? 0 : len - 1;
   endfunction

   function automatic rsp_type predict_tuple(req_type t);
      logic [LEN_W-1:0]  len;
      logic [SIZE_W-1:0] sz [NUM_POS];
      logic [GRP_W-1:0]  gp [NUM_POS];
      logic [WK_W-1:0]   saved [NUM_POS];
      logic              found;
      logic              close;
      logic              more;
      rsp_type           r;
      found = 1'b0;
      close = 1'b0;
      if (t.mode == MODE_LOAD) begin
         len = t.tuple_length;
         if (len < LEN_W'(1))
            len = LEN_W'(1);
         if (len > LEN_W'(LEN_LIM))
            len = LEN_W'(LEN_LIM);
         cur_length = len;
         sz = '{t.size_0, t.size_1, t.size_2, t.size_3};
         gp = '{t.group_0, t.group_1, t.group_2, t.group_3};
         for (int i = 0; i < NUM_POS; i++) begin
            cur_size[i]  = (sz[i] > MAX_GROUP_SIZE) ? SIZE_W'(MAX_GROUP_SIZE) : sz[i];
            cur_group[i] = GRP_W'(gp[i] % NUM_GROUPS);
            probe[i]     = '0;
         end
         final_set = t.last_set;
         found = first_tuple(enum_span());
      end else if (set_open) begin
         for (int i = 0; i < NUM_POS; i++)
            probe[i] = WK_W'(cur_index[i]);
         if (!full_mode && cur_length >= 1 && cur_length <= NUM_POS)
            probe[cur_length - 1] = '0;
         found = next_tuple(enum_span());
      end

      for (int i = 0; i < NUM_POS; i++)
         cur_index[i] = (found && i < cur_length) ? probe[i][IDX_W-1:0] : '0;
      set_open = found;

      if (full_mode) begin
         if (found) begin
            batch_fill = batch_fill + 1'b1;
            if (batch_fill >= batch_limit) begin
               close = 1'b1;
               batch_fill = '0;
            end else if (final_set) begin
               saved = probe;
               more = next_tuple(enum_span());
               probe = saved;
               if (!more) begin
                  close = 1'b1;
                  batch_fill = '0;
               end
            end
         end else if (final_set && batch_fill != 0) begin
            close = 1'b1;
            batch_fill = '0;
         end
      end

      r.index_0   = cur_index[0];
      r.index_1   = cur_index[1];
      r.index_2   = cur_index[2];
      r.index_3   = cur_index[3];
      r.valid_res = found;
      r.batch_end = close;
      return r;
   endfunction

   function automatic int compare_tuple(rsp_type want, rsp_type got);
      int bad;
      bad = 0;
      if (got.index_0 !== want.index_0) begin
         $error("index_0: expected %0d, actual %0d", want.index_0, got.index_0);
         bad++;
      end
      if (got.index_1 !== want.index_1) begin
         $error("index_1: expected %0d, actual %0d", want.index_1, got.index_1);
         bad++;
      end
      if (got.index_2 !== want.index_2) begin
         $error("index_2: expected %0d, actual %0d", want.index_2, got.index_2);
         bad++;
      end
      if (got.index_3 !== want.index_3) begin
         $error("index_3: expected %0d, actual %0d", want.index_3, got.index_3);
         bad++;
      end
      if (got.valid_res !== want.valid_res) begin
         $error("valid_res: expected %0d, actual %0d", want.valid_res, got.valid_res);
         bad++;
      end
      if (got.batch_end !== want.batch_end) begin
         $error("batch_end: expected %0d, actual %0d", want.batch_end, got.batch_end);
         bad++;
      end
      return bad;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      if (reset) begin
         full_mode   = 1'b0;
         batch_limit = BATCH_RESET;
         for (int i = 0; i < NUM_POS; i++) begin
            cur_index[i] = '0;
            cur_group[i] = '0;
            cur_size[i]  = '0;
            probe[i]     = '0;
         end
         cur_length = '0;
         set_open   = 1'b0;
         final_set  = 1'b0;
         batch_fill = '0;
         tuples_due.delete();
         error_count  <= 0;
         outstanding  <= 0;
         result_count <= 0;
         tuple_count  <= 0;
         close_count  <= 0;
      end else begin
         bad = 0;
         if (csr_we) begin
            if (csr_index == CSR_ENUMERATE_LAST)
               full_mode = csr_wdata[0];
            else if (csr_index == CSR_BATCH_SIZE)
               batch_limit = csr_wdata;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (tuples_due.size() == 0) begin
               $error("result with no transaction outstanding: %h", rsp_data);
               bad = 1;
            end else begin
               want = tuples_due.pop_front();
               bad = compare_tuple(want, rsp_data);
            end
            result_count <= result_count + 1;
            tuple_count  <= tuple_count + rsp_data.valid_res;
            close_count  <= close_count + rsp_data.batch_end;
         end
         if (req_valid && req_ready === 1'b1)
            tuples_due.insert(tuples_due.size(), predict_tuple(req_data));
         error_count <= error_count + bad;
         outstanding <= tuples_due.size();
      end
   end

endmodule

// ===== test/tb_grouped_tuple_enumerator_top.sv =====
// Testbench top for the grouped tuple enumerator: clock, reset, register writes, request
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on gte_pkg, grouped_tuple_enumerator_top and tb_grouped_tuple_enumerator_checker.
`timescale 1ns / 1ps

module tb_grouped_tuple_enumerator_top;
   import gte_pkg::*;

   localparam int WATCHDOG_LIMIT     = 200000;
   localparam int SETTING_COUNT      = 10;
   localparam int RANDOM_PER_SETTING = 183;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int outstanding;
   int result_count;
   int tuple_count;
   int close_count;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   logic             full_list  [SETTING_COUNT] = '{1, 1, 1, 0, 1, 1, 0, 1, 1, 1};
   logic [CNT_W-1:0] batch_list [SETTING_COUNT] = '{10, 1, 65535, 3, 0, 2, 65535, 5, 7, 4};

   always #6 clock = ~clock;

   grouped_tuple_enumerator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tb_grouped_tuple_enumerator_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .result_count (result_count),
      .tuple_count  (tuple_count),
      .close_count  (close_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic req_type random_advance();
      logic [63:0] raw;
      req_type     r;
      raw = {$urandom(), $urandom()};
      r = raw[$bits(req_type)-1:0];
      r.mode = MODE_ADVANCE;
      return r;
   endfunction

   // Mostly small sizes; one large position at a time keeps the search of empty subtrees short.
   // The wide shape has at most two active positions, so every size bit can be random.
   function automatic req_type random_load();
      logic [63:0]       raw;
      req_type           r;
      logic [GRP_W-1:0]  pool_a;
      logic [GRP_W-1:0]  pool_b;
      logic [GRP_W-1:0]  gp [NUM_POS];
      logic [SIZE_W-1:0] sz [NUM_POS];
      int                shape;
      int                big_pos;
      raw = {$urandom(), $urandom()};
      r = raw[$bits(req_type)-1:0];
      r.mode = MODE_LOAD;
      r.last_set = ($urandom_range(2) == 0);
      pool_a = GRP_W'($urandom());
      pool_b = GRP_W'($urandom());
      shape = $urandom_range(19);
      big_pos = $urandom_range(NUM_POS - 1);
      for (int i = 0; i < NUM_POS; i++) begin
         if ($urandom_range(1) == 0)
            gp[i] = ($urandom_range(1) == 0) ? pool_a : pool_b;
         else
            gp[i] = GRP_W'($urandom());
         if (shape == 0)
            sz[i] = SIZE_W'($urandom());
         else if (shape == 1)
            sz[i] = (i == big_pos) ? SIZE_W'($urandom_range(8, 511)) : SIZE_W'($urandom_range(3));
         else
            sz[i] = SIZE_W'($urandom_range(6));
      end
      if (shape == 0)
         r.tuple_length = LEN_W'($urandom_range(2));
      {r.group_0, r.group_1, r.group_2, r.group_3} = {gp[0], gp[1], gp[2], gp[3]};
      {r.size_0, r.size_1, r.size_2, r.size_3} = {sz[0], sz[1], sz[2], sz[3]};
      return r;
   endfunction

   task automatic load_set(input logic [LEN_W-1:0] len, input logic [4*GRP_W-1:0] groups,
                           input logic [4*SIZE_W-1:0] sizes, input logic last);
      req_type r;
      r = random_advance();
      r.mode = MODE_LOAD;
      r.tuple_length = len;
      {r.group_0, r.group_1, r.group_2, r.group_3} = groups;
      {r.size_0, r.size_1, r.size_2, r.size_3} = sizes;
      r.last_set = last;
      send_item(r);
   endtask

   task automatic run_random(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(49) == 0)
            drain_results();
         if ($urandom_range(99) < 12) begin
            send_item(random_advance());
            sent++;
         end else begin
            send_item(random_load());
            sent++;
            burst = ($urandom_range(5) == 0) ? $urandom_range(60) : $urandom_range(8);
            repeat (burst) begin
               send_item(random_advance());
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [CNT_W-1:0] batch;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Completion mode after reset.
      send_item(random_advance());
      load_set(3'd0, {4'd0, 4'd0, 4'd0, 4'd0}, {9'd0, 9'd0, 9'd0, 9'd0}, 1'b0);
      send_item(random_advance());
      load_set(3'd7, {4'd15, 4'd15, 4'd15, 4'd15}, {9'd511, 9'd511, 9'd511, 9'd511}, 1'b1);
      send_item(random_advance());
      load_set(3'd2, {4'd0, 4'd15, 4'd0, 4'd0}, {9'd256, 9'd0, 9'd0, 9'd0}, 1'b0);
      send_item(random_advance());

      // Full mode with short batches.
      write_reg(CSR_ENUMERATE_LAST, 16'd1);
      write_reg(CSR_BATCH_SIZE, 16'd3);
      load_set(3'd2, {4'd0, 4'd15, 4'd0, 4'd0}, {9'd256, 9'd0, 9'd0, 9'd0}, 1'b0);
      load_set(3'd3, {4'd5, 4'd5, 4'd5, 4'd0}, {9'd3, 9'd3, 9'd3, 9'd0}, 1'b1);
      send_item(random_advance());
      load_set(3'd2, {4'd1, 4'd2, 4'd0, 4'd0}, {9'd2, 9'd2, 9'd0, 9'd0}, 1'b0);
      repeat (3) send_item(random_advance());
      load_set(3'd1, {4'd9, 4'd0, 4'd0, 4'd0}, {9'd0, 9'd0, 9'd0, 9'd0}, 1'b1);
      load_set(3'd2, {4'd4, 4'd4, 4'd0, 4'd0}, {9'd3, 9'd1, 9'd0, 9'd0}, 1'b0);
      load_set(3'd4, {4'd0, 4'd1, 4'd2, 4'd3}, {9'd256, 9'd256, 9'd256, 9'd256}, 1'b0);
      send_item(random_advance());
      load_set(3'd2, {4'd6, 4'd7, 4'd0, 4'd0}, {9'd3, 9'd3, 9'd0, 9'd0}, 1'b1);
      send_item(random_advance());

      // The mode changes while a set is still live.
      write_reg(CSR_ENUMERATE_LAST, 16'd0);
      send_item(random_advance());
      write_reg(CSR_ENUMERATE_LAST, 16'd1);
      send_item(random_advance());

      for (int k = 0; k < SETTING_COUNT; k++) begin
         batch = batch_list[k];
         if (k == SETTING_COUNT - 1)
            batch = CNT_W'($urandom_range(1, 40));
         write_reg(CSR_ENUMERATE_LAST, {15'($urandom()), full_list[k]});
         write_reg(CSR_BATCH_SIZE, batch);
         case (k % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 68;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 68;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct     = 19;
            end
         endcase
         run_random(RANDOM_PER_SETTING);
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("Summary: %0d transactions over %0d register settings and four idling phases.",
               items_sent, SETTING_COUNT + 2);
      $display("Summary: %0d results checked, %0d tuples delivered, %0d batch ends.",
               result_count, tuple_count, close_count);
      if (error_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
